// ===== rtl/sdlf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdlf_pkg
// Types and codes shared by the start/escape length-framed byte receiver.
// ----------------------------------------------------------------------------
package sdlf_pkg;

    // receive mode codes
    localparam logic [2:0] MODE_HUNT  = 3'd0;
    localparam logic [2:0] MODE_LEN   = 3'd1;
    localparam logic [2:0] MODE_DATA  = 3'd2;
    localparam logic [2:0] MODE_ESC_L = 3'd3;
    localparam logic [2:0] MODE_ESC_D = 3'd4;

    // configuration register indexes
    localparam logic [7:0] REG_START_BYTE  = 8'd0;
    localparam logic [7:0] REG_ESCAPE_BYTE = 8'd1;

    // register reset values
    localparam logic [7:0] START_BYTE_RST  = 8'h02;
    localparam logic [7:0] ESCAPE_BYTE_RST = 8'h10;

    // configuration write word
    typedef struct packed {
        logic [7:0] index;
        logic [7:0] value;
    } sdlf_cfg_t;

    // one result word
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [5:0] byte_index;
        logic       last_in_frame;
    } sdlf_result_t;

endpackage

// ===== rtl/sdlf_stream_if.sv =====
// ----------------------------------------------------------------------------
// sdlf_stream_if
// Valid/ready channel carrying one word of type T per handshake.
// ----------------------------------------------------------------------------
interface sdlf_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sdlf_out_buf.sv =====
// ----------------------------------------------------------------------------
// sdlf_out_buf
// Two-word output buffer: an output register plus a skid register, so the
// receiver keeps taking bytes while a result word waits downstream.
// ----------------------------------------------------------------------------
module sdlf_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sdlf_pkg::sdlf_result_t push_data,
    output logic                  push_ready,
    sdlf_stream_if.source         result
);
    import sdlf_pkg::*;

    logic         head_valid_reg, head_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    sdlf_result_t head_reg, head_next;
    sdlf_result_t skid_reg, skid_next;
    logic         pop;

    assign pop          = head_valid_reg && result.ready;
    assign push_ready   = !skid_valid_reg;
    assign result.valid = head_valid_reg;
    assign result.data  = head_reg;

    // buffer next state
    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (push && (!head_valid_reg || pop))
        begin
            head_next       = push_data;
            head_valid_next = 1'b1;
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_valid_next = 1'b0;
            end
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload flops
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== rtl/stx_dle_length_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// stx_dle_length_frame_receiver_top
// Start/escape byte deframer with a length byte and indexed payload output.
// ----------------------------------------------------------------------------
// One received byte is taken every clock cycle while the output buffer has
// room; each goes through the mode, length and count registers. A payload
// byte appears on the result channel in the cycle after it is taken when the
// output register is free, otherwise it waits in the skid register until the
// word ahead of it is taken. Each payload word carries its index and a last
// flag (set when the count reaches the length, a length of zero counting as
// one, or MAX_FRAME). A two-word output buffer lets input continue while one
// result word is held off downstream; input stalls only when both buffer
// words are full. The block does not guard the cfg channel: the user must
// write start/escape bytes (indexes 0 and 1) only while the block is idle.
// ----------------------------------------------------------------------------
module stx_dle_length_frame_receiver_top #(
    parameter int MAX_FRAME = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    sdlf_stream_if.sink   cfg,
    sdlf_stream_if.sink   rx,
    sdlf_stream_if.source result
);
    import sdlf_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    logic [7:0]       start_byte_reg;
    logic [7:0]       escape_byte_reg;
    logic [2:0]       mode_reg, mode_next;
    logic [7:0]       length_reg, length_next;
    logic [CNT_W-1:0] count_reg, count_next;

    sdlf_cfg_t        cfg_word;
    logic [7:0]       rx_word;
    logic             accept;
    logic             emit;
    logic             push_ready;
    sdlf_result_t     res_word;
    logic [8:0]       eff_len;
    logic [8:0]       next_cnt;
    logic [7:0]       cnt_wide;
    logic             last;
    logic             is_start;
    logic             is_escape;

    assign cfg_word  = cfg.data;
    assign rx_word   = rx.data;
    assign cfg.ready = 1'b1;
    assign rx.ready  = push_ready;
    assign accept    = rx.valid && push_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= START_BYTE_RST;
            escape_byte_reg <= ESCAPE_BYTE_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg_word.index == REG_START_BYTE)
            begin
                start_byte_reg <= cfg_word.value;
            end
            else if (cfg_word.index == REG_ESCAPE_BYTE)
            begin
                escape_byte_reg <= cfg_word.value;
            end
        end
    end

    // byte classification and end-of-frame test
    assign is_start  = (rx_word == start_byte_reg);
    assign is_escape = (rx_word == escape_byte_reg);
    assign eff_len   = (length_reg == 8'd0) ? 9'd1 : {1'b0, length_reg};
    assign next_cnt  = 9'(count_reg) + 9'd1;
    assign last      = (next_cnt >= eff_len) || (next_cnt >= 9'(MAX_FRAME));
    assign cnt_wide  = 8'(count_reg);

    // receive mode sequencing
    always_comb
    begin
        mode_next   = mode_reg;
        length_next = length_reg;
        count_next  = count_reg;
        emit        = 1'b0;
        case (mode_reg)
            MODE_LEN:
            begin
                if (is_start)
                begin
                    mode_next  = MODE_HUNT;
                    count_next = '0;
                end
                else if (is_escape)
                begin
                    mode_next = MODE_ESC_L;
                end
                else
                begin
                    length_next = rx_word;
                    mode_next   = MODE_DATA;
                end
            end
            MODE_DATA:
            begin
                if (is_start)
                begin
                    mode_next  = MODE_HUNT;
                    count_next = '0;
                end
                else if (is_escape)
                begin
                    mode_next = MODE_ESC_D;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            MODE_ESC_L:
            begin
                length_next = rx_word;
                mode_next   = MODE_DATA;
            end
            MODE_ESC_D:
            begin
                emit = 1'b1;
            end
            default:
            begin
                if (is_start)
                begin
                    count_next = '0;
                    mode_next  = MODE_LEN;
                end
                else
                begin
                    mode_next = MODE_HUNT;
                end
            end
        endcase
        // payload byte advances or closes the frame
        if (emit)
        begin
            if (last)
            begin
                count_next = '0;
                mode_next  = MODE_HUNT;
            end
            else
            begin
                count_next = CNT_W'(next_cnt);
                mode_next  = MODE_DATA;
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HUNT;
            length_reg <= 8'd0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

    // result word
    assign res_word.payload_byte  = rx_word;
    assign res_word.byte_index    = cnt_wide[5:0];
    assign res_word.last_in_frame = last;

    sdlf_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && emit),
        .push_data  (res_word),
        .push_ready (push_ready),
        .result     (result)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the start/escape length-framed byte receiver.
// ----------------------------------------------------------------------------
// Byte words are fed on the rx channel from a queue filled by the stimulus
// process, with random gaps. Every accepted byte runs through a bench-side
// deframer that produces the expected result words. Results are taken with
// random stalls and checked in order. Start and escape bytes are rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import sdlf_pkg::*;

    localparam int MAX_FRAME   = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;

    // register indexes with no register behind them
    localparam logic [7:0] REG_SPARE = 8'h02;
    localparam logic [7:0] REG_TOP   = 8'hFF;

    logic clk;
    logic rst_n;

    sdlf_stream_if #(.T(sdlf_cfg_t))    cfg_if ();
    sdlf_stream_if                      rx_if ();
    sdlf_stream_if #(.T(sdlf_result_t)) result_if ();

    stx_dle_length_frame_receiver_top #(
        .MAX_FRAME(MAX_FRAME)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_if),
        .rx(rx_if),
        .result(result_if)
    );

    // bytes waiting to be offered, expected result words
    logic [7:0]   rx_bytes_pending[$];
    sdlf_result_t expected_words[$];

    // bench-side deframer state and register copies
    logic [2:0] pred_mode;
    logic [7:0] pred_len;
    logic [7:0] pred_count;
    logic [7:0] pred_start;
    logic [7:0] pred_escape;

    // register values the stimulus builds frames for
    logic [7:0] gen_start;
    logic [7:0] gen_escape;

    int  mismatches;
    int  rx_taken;
    int  cycle_count;
    int  send_gap;
    int  recv_gap;
    bit  idle_on;
    bit  hold_off;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one received byte through the deframer, returns 1 when a word comes out
    function automatic bit deframe_byte(input logic [7:0] b, output sdlf_result_t word);
        logic [8:0] need;
        logic [8:0] reached;
        bit         emit;
        bit         done;
        emit = 1'b0;
        word = '0;
        case (pred_mode)
            MODE_LEN:
            begin
                if (b == pred_start)
                begin
                    pred_count = '0;
                    pred_mode  = MODE_HUNT;
                end
                else if (b == pred_escape)
                    pred_mode = MODE_ESC_L;
                else
                begin
                    pred_len  = b;
                    pred_mode = MODE_DATA;
                end
            end
            MODE_DATA:
            begin
                if (b == pred_start)
                begin
                    pred_count = '0;
                    pred_mode  = MODE_HUNT;
                end
                else if (b == pred_escape)
                    pred_mode = MODE_ESC_D;
                else
                    emit = 1'b1;
            end
            MODE_ESC_L:
            begin
                pred_len  = b;
                pred_mode = MODE_DATA;
            end
            MODE_ESC_D:
                emit = 1'b1;
            default:
            begin
                if (b == pred_start)
                begin
                    pred_count = '0;
                    pred_mode  = MODE_LEN;
                end
                else
                    pred_mode = MODE_HUNT;
            end
        endcase
        if (emit)
        begin
            // zero length counts as one, the frame ends at MAX_FRAME
            need    = (pred_len == 8'd0) ? 9'd1 : {1'b0, pred_len};
            reached = {1'b0, pred_count} + 9'd1;
            done    = (reached >= need) || (reached >= MAX_FRAME);
            word    = '{b, pred_count[5:0], done};
            if (done)
            begin
                pred_count = '0;
                pred_mode  = MODE_HUNT;
            end
            else
            begin
                pred_count = reached[7:0];
                pred_mode  = MODE_DATA;
            end
        end
        return emit;
    endfunction

    // rx driver: hold the word until taken, then a random gap
    always @(posedge clk or negedge rst_n)
    begin : rx_driver
        bit taken;
        if (!rst_n)
        begin
            rx_if.valid <= 1'b0;
            rx_if.data  <= '0;
            send_gap = 0;
        end
        else
        begin
            taken = rx_if.valid && rx_if.ready;
            if (taken)
            begin
                void'(rx_bytes_pending.pop_front());
                send_gap = pick_gap();
            end
            if (rx_if.valid && !taken)
                rx_if.valid <= 1'b1;
            else if (send_gap > 0)
            begin
                send_gap--;
                rx_if.valid <= 1'b0;
            end
            else if (rx_bytes_pending.size() > 0)
            begin
                rx_if.valid <= 1'b1;
                rx_if.data  <= rx_bytes_pending[0];
            end
            else
                rx_if.valid <= 1'b0;
        end
    end

    // result ready: stalls after taken words, plus the long hold-off
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
                recv_gap = pick_gap();
            if (hold_off)
                result_if.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    // monitor: check results, track register writes, predict accepted bytes
    always @(posedge clk or negedge rst_n)
    begin : monitor
        sdlf_result_t got;
        sdlf_result_t want;
        if (!rst_n)
        begin
            pred_mode   = MODE_HUNT;
            pred_len    = '0;
            pred_count  = '0;
            pred_start  = START_BYTE_RST;
            pred_escape = ESCAPE_BYTE_RST;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                got = result_if.data;
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: byte %h index %0d last %b",
                                 got.payload_byte, got.byte_index, got.last_in_frame);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.payload_byte !== want.payload_byte
                        || got.byte_index !== want.byte_index
                        || got.last_in_frame !== want.last_in_frame)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h %0d %b, got %h %0d %b",
                                     want.payload_byte, want.byte_index, want.last_in_frame,
                                     got.payload_byte, got.byte_index, got.last_in_frame);
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready)
            begin
                if (cfg_if.data.index == REG_START_BYTE)
                    pred_start = cfg_if.data.value;
                else if (cfg_if.data.index == REG_ESCAPE_BYTE)
                    pred_escape = cfg_if.data.value;
            end
            if (rx_if.valid && rx_if.ready)
            begin
                rx_taken++;
                if (deframe_byte(rx_if.data, want))
                    expected_words.push_back(want);
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // long receiver hold-off once traffic is under way, so the input backs up
    initial
    begin
        hold_off = 1'b0;
        wait (rx_taken >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, value: val};
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        if (idx == REG_START_BYTE)
            gen_start = val;
        else if (idx == REG_ESCAPE_BYTE)
            gen_escape = val;
    endtask

    // all bytes taken and all words back, then a quiet pause
    task automatic wait_idle();
        while (rx_bytes_pending.size() != 0 || rx_if.valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // escape a byte that would otherwise be taken as a control byte, or alter it
    task automatic push_stuffed(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (v == gen_start || v == gen_escape)
        begin
            // with equal start and escape bytes there is no way to escape
            if (gen_start == gen_escape)
                v = v + 8'd1;
            else
                rx_bytes_pending.push_back(gen_escape);
        end
        rx_bytes_pending.push_back(v);
    endtask

    function automatic logic [7:0] pick_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return gen_start;
        if (r < 20)
            return gen_escape;
        return 8'($urandom);
    endfunction

    // one frame, optionally cut off by a bare start byte
    task automatic send_frame(input int len, input bit cut_short);
        int full;
        int n;
        full = (len == 0) ? 1 : ((len < MAX_FRAME) ? len : MAX_FRAME);
        n    = cut_short ? $urandom_range(0, full - 1) : full;
        rx_bytes_pending.push_back(gen_start);
        push_stuffed(8'(len));
        repeat (n) push_stuffed(pick_payload());
        if (cut_short)
            rx_bytes_pending.push_back(gen_start);
    endtask

    // mostly well-formed frames, some cut short, some line noise
    task automatic send_traffic(input int n_bytes);
        int target;
        int r;
        int len;
        target = rx_bytes_pending.size() + n_bytes;
        send_frame(255, 1'b0);
        while (rx_bytes_pending.size() < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    len = $urandom_range(0, 8);
                else if (r < 9)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(41, 255);
                send_frame(len, 1'b0);
            end
            else if (r < 85)
                send_frame($urandom_range(0, 12), 1'b1);
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    r = $urandom_range(0, 3);
                    if (r == 0)
                        rx_bytes_pending.push_back(gen_start);
                    else if (r == 1)
                        rx_bytes_pending.push_back(gen_escape);
                    else
                        rx_bytes_pending.push_back(8'($urandom));
                end
            end
        end
    endtask

    // main sequence
    initial
    begin
        logic [7:0] a;
        logic [7:0] b;
        rst_n           = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        rx_if.valid     = 1'b0;
        rx_if.data      = '0;
        result_if.ready = 1'b0;
        mismatches      = 0;
        rx_taken        = 0;
        cycle_count     = 0;
        idle_on         = 1'b1;
        gen_start       = START_BYTE_RST;
        gen_escape      = ESCAPE_BYTE_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed bytes with the reset start and escape values
        rx_bytes_pending = {
            // noise while hunting, a bare escape included
            8'h00, 8'hFF, gen_escape,
            // zero length acts as one
            gen_start, 8'h00, 8'hFF,
            // escaped length, escaped escape and escaped start in the payload
            gen_start, gen_escape, gen_start, gen_escape, gen_escape, gen_escape, gen_start,
            // bare start in the payload aborts, the next byte is not a start
            gen_start, 8'h03, 8'hAA, gen_start, 8'h05,
            // bare start in place of the length
            gen_start, gen_start,
            // one byte frame
            gen_start, 8'h01, 8'h00
        };
        send_traffic(130);
        wait_idle();

        // extremes: start 0x00, escape 0xFF
        write_reg(REG_START_BYTE, 8'h00);
        write_reg(REG_ESCAPE_BYTE, 8'hFF);
        send_traffic(150);
        wait_idle();

        // extremes the other way round, no idling on either side
        write_reg(REG_START_BYTE, 8'hFF);
        write_reg(REG_ESCAPE_BYTE, 8'h00);
        idle_on = 1'b0;
        send_traffic(150);
        wait_idle();

        // equal start and escape bytes, plus a write to an unused index
        a = 8'($urandom);
        write_reg(REG_START_BYTE, a);
        write_reg(REG_ESCAPE_BYTE, a);
        write_reg(REG_SPARE, ~a);
        idle_on = 1'b1;
        send_traffic(150);
        wait_idle();

        // random distinct values
        a = 8'($urandom);
        b = 8'($urandom);
        if (b == a)
            b = a ^ 8'h80;
        write_reg(REG_START_BYTE, a);
        write_reg(REG_ESCAPE_BYTE, b);
        write_reg(REG_TOP, a ^ b);
        send_traffic(150);
        wait_idle();

        // back to the reset values
        write_reg(REG_START_BYTE, START_BYTE_RST);
        write_reg(REG_ESCAPE_BYTE, ESCAPE_BYTE_RST);
        send_traffic(150);
        wait_idle();

        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
